@@ rtl/core/txrdf_pkg.sv @@
// Shared types and constants for the transmit ring DMA burst feeder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package txrdf_pkg;

  localparam int DEPTH_DEFAULT = 512;
  localparam int FIELD_W       = 9;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       commit;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic               burst_start;
    logic [FIELD_W-1:0] burst_addr;
    logic [FIELD_W-1:0] burst_len;
    logic               uart_enable;
    logic               uart_disable;
    logic [FIELD_W-1:0] used_count;
    logic               running;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/tx_ring_dma_burst_feeder.sv @@
// Top level of the transmit ring DMA burst feeder.
// Depends on txrdf_pkg, txrdf_in_stage and txrdf_ring_ctrl.
//
// Usage:
//   Input channel: a command word on in_item is taken at each rising edge
//   where start is high and busy is low. busy stays low, so one word can be
//   taken every cycle. Kinds: write a byte, DMA transfer done, status query.
//   Result channel: out_valid pulses for one cycle with out_item holding the
//   result of one command: write accepted, burst issued (address and length
//   within the ring), UART enable/disable, queued byte count and the DMA
//   chain flag after the command.
//   Path: a taken word passes two register stages, the input register and then
//   the result register, before its result is presented on out_item.
//   Throughput: one command per cycle; pointer update and burst sizing finish
//   in the cycle between the two registers.
//   Reset (rst_n low, synchronous): head and tail go to zero, the chain flag
//   clears and any command in flight is dropped. The byte store is not
//   cleared; its contents are undefined until written.
//   The receiver cannot stall: results are presented once and not held.
`timescale 1ns / 1ps
`default_nettype none

module tx_ring_dma_burst_feeder #(
  parameter int DEPTH = txrdf_pkg::DEPTH_DEFAULT
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  txrdf_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output txrdf_pkg::out_item_t out_item
);
  import txrdf_pkg::*;

  logic     take;
  logic     item_valid;
  in_item_t item_q;

  assign busy = 1'b0;
  assign take = start && !busy;

  txrdf_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .item       (in_item),
    .item_valid (item_valid),
    .item_q     (item_q)
  );

  txrdf_ring_ctrl #(
    .DEPTH (DEPTH)
  ) u_ring_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item_q),
    .res_valid  (out_valid),
    .res        (out_item)
  );

endmodule

`default_nettype wire

@@ rtl/core/txrdf_in_stage.sv @@
// Input register of the ring feeder: captures one command word per cycle.
// Depends on txrdf_pkg for the input word type.
`timescale 1ns / 1ps
`default_nettype none

module txrdf_in_stage (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 take,
  input  txrdf_pkg::in_item_t item,
  output logic                item_valid,
  output txrdf_pkg::in_item_t item_q
);
  import txrdf_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item;
    end
  end

  assign item_valid = valid_r;
  assign item_q     = item_r;

endmodule

`default_nettype wire

@@ rtl/core/txrdf_ring_ctrl.sv @@
// Ring pointers, DMA chain flag, byte store and result register.
// Depends on txrdf_pkg for the word types and command codes.
`timescale 1ns / 1ps
`default_nettype none

module txrdf_ring_ctrl #(
  parameter int DEPTH = txrdf_pkg::DEPTH_DEFAULT
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  item_valid,
  input  txrdf_pkg::in_item_t  item,
  output logic                 res_valid,
  output txrdf_pkg::out_item_t res
);
  import txrdf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = PW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] FULL_C  = CW'(DEPTH - 1);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  logic [7:0]    ring_mem [DEPTH];

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic          active_r, active_nxt;
  logic          res_valid_r;
  out_item_t     res_r, res_nxt;

  logic [CW-1:0] head_x, tail_x, used, tail_inc, tail_w, used_w;
  logic [CW-1:0] tail_s, contig, head_sum, head_f, used_after;
  logic          is_write, is_done, full, wr_ok, wrapped, check, kick;
  logic          feed, burst, drain;

  always_comb begin
    head_x   = {1'b0, head_r};
    tail_x   = {1'b0, tail_r};
    used     = (tail_x >= head_x) ? tail_x - head_x : tail_x + DEPTH_C - head_x;
    is_write = (item.kind == KIND_WRITE);
    is_done  = (item.kind == KIND_DONE);
    full     = (used == FULL_C);
    wr_ok    = item_valid && is_write && !full;

    tail_inc = tail_x + ONE_C;
    wrapped  = (tail_inc == DEPTH_C);
    tail_w   = wrapped ? '0 : tail_inc;
    used_w   = used + ONE_C;
    check    = item.commit || wrapped || (used_w == FULL_C);
    kick     = wr_ok && check && !active_r;

    // burst runs from head to the new tail, or to the end of the ring on wrap
    tail_s   = wr_ok ? tail_w : tail_x;
    contig   = (tail_s >= head_x) ? tail_s - head_x : DEPTH_C - head_x;
    feed     = kick || (item_valid && is_done && active_r);
    burst    = feed && (contig != '0);
    drain    = feed && (contig == '0);

    head_sum = head_x + contig;
    head_f   = (head_sum >= DEPTH_C) ? head_sum - DEPTH_C : head_sum;

    head_nxt = burst ? head_f[PW-1:0] : head_r;
    tail_nxt = tail_s[PW-1:0];
    if (kick) begin
      active_nxt = 1'b1;
    end else if (drain) begin
      active_nxt = 1'b0;
    end else begin
      active_nxt = active_r;
    end

    used_after = (wr_ok ? used_w : used) - (burst ? contig : '0);

    res_nxt              = '0;
    res_nxt.accepted     = wr_ok;
    res_nxt.burst_start  = burst;
    res_nxt.burst_addr   = burst ? FIELD_W'(head_r) : '0;
    res_nxt.burst_len    = burst ? FIELD_W'(contig) : '0;
    res_nxt.uart_enable  = kick;
    res_nxt.uart_disable = drain;
    res_nxt.used_count   = FIELD_W'(used_after);
    res_nxt.running      = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      active_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      active_r    <= active_nxt;
      res_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // store the byte at the old tail
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      ring_mem[tail_r] <= item.data_byte;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

@@ rtl/core/txrdf_checker.sv @@
// Port-level checks for the transmit ring DMA burst feeder, bound to the top.
// Depends on txrdf_pkg and tx_ring_dma_burst_feeder.
`timescale 1ns / 1ps
`default_nettype none

module txrdf_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  start,
  input wire                  busy,
  input wire                  out_valid,
  input txrdf_pkg::out_item_t out_item
);
  import txrdf_pkg::*;

  // each taken word yields exactly one result, after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result missing two cycles after a taken word");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> ##1 !out_valid)
    else $error("result without a taken word");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.burst_start) |->
      (out_item.burst_addr == '0 && out_item.burst_len == '0))
    else $error("burst fields set without a burst");

  a_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.uart_enable) |->
      (out_item.burst_start && out_item.running && out_item.accepted))
    else $error("UART enabled without a burst on a running chain");

  a_disable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.uart_disable) |->
      (!out_item.burst_start && !out_item.running && !out_item.uart_enable))
    else $error("UART disabled while a chain still runs");

endmodule

bind tx_ring_dma_burst_feeder txrdf_checker u_txrdf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

@@ tb/sv/tx_ring_dma_burst_feeder_tb.sv @@
// Self-checking testbench for tx_ring_dma_burst_feeder: directed ring fills and wraps,
// then paced random command words, checked against an in-bench model of the ring.
// Depends on txrdf_pkg and the tx_ring_dma_burst_feeder RTL.
`timescale 1ns / 1ps

module tx_ring_dma_burst_feeder_tb;
  import txrdf_pkg::*;

  localparam int RING_DEPTH     = DEPTH_DEFAULT;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int RANDOM_WORDS   = 210;
  localparam int MAX_PRINTED    = 30;

  // Tracks head, tail and chain state and queues the expected result per word.
  class burst_scoreboard;
    int unsigned head;
    int unsigned tail;
    bit          chain_on;
    out_item_t   expected_q[$];
    int          errors;

    function new();
      head     = 0;
      tail     = 0;
      chain_on = 1'b0;
      errors   = 0;
    endfunction

    function int unsigned queued_bytes();
      if (tail >= head) return tail - head;
      return tail + RING_DEPTH - head;
    endfunction

    function int unsigned contig_bytes();
      if (tail >= head) return tail - head;
      return RING_DEPTH - head;
    endfunction

    // Hand the contiguous run at the head to the DMA, or end the chain.
    function void feed_burst(inout out_item_t r);
      int unsigned n;
      n = contig_bytes();
      if (n == 0) begin
        chain_on       = 1'b0;
        r.uart_disable = 1'b1;
      end else begin
        r.burst_start = 1'b1;
        r.burst_addr  = head[FIELD_W-1:0];
        r.burst_len   = n[FIELD_W-1:0];
        head          = head + n;
        if (head >= RING_DEPTH) head = head - RING_DEPTH;
      end
    endfunction

    function out_item_t predict_result(in_item_t w);
      out_item_t   r;
      bit          wrapped;
      bit          kick;
      int unsigned used;
      r = '0;
      if (w.kind == KIND_WRITE) begin
        if (queued_bytes() < RING_DEPTH - 1) begin
          tail    = tail + 1;
          wrapped = 1'b0;
          if (tail >= RING_DEPTH) begin
            tail    = 0;
            wrapped = 1'b1;
          end
          r.accepted = 1'b1;
          kick = w.commit || wrapped || (queued_bytes() == RING_DEPTH - 1);
          if (kick && !chain_on && queued_bytes() > 0) begin
            chain_on      = 1'b1;
            r.uart_enable = 1'b1;
            feed_burst(r);
          end
        end
      end else if (w.kind == KIND_DONE) begin
        if (chain_on) feed_burst(r);
      end
      used       = queued_bytes();
      r.used_count = used[FIELD_W-1:0];
      r.running  = chain_on;
      return r;
    endfunction

    function void note_word(in_item_t w);
      expected_q.push_back(predict_result(w));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("ERROR %0t: %s", $time, what);
    endtask

    task compare_field(string name, int unsigned got, int unsigned exp);
      if (got != exp)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp));
    endtask

    task check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        exp = expected_q.pop_front();
        compare_field("accepted", got.accepted, exp.accepted);
        compare_field("burst_start", got.burst_start, exp.burst_start);
        compare_field("burst_addr", got.burst_addr, exp.burst_addr);
        compare_field("burst_len", got.burst_len, exp.burst_len);
        compare_field("uart_enable", got.uart_enable, exp.uart_enable);
        compare_field("uart_disable", got.uart_disable, exp.uart_disable);
        compare_field("used_count", got.used_count, exp.used_count);
        compare_field("running", got.running, exp.running);
      end
    endtask
  endclass

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  burst_scoreboard sb = new();

  int burst_left = 0;
  int flood_left = 0;
  int idle_count = 0;
  bit drive_on   = 1'b0;

  tx_ring_dma_burst_feeder #(
    .DEPTH(RING_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Check the older result before noting the word taken at the same edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_item);
    if (rst_n && start && busy === 1'b0) sb.note_word(in_item);
  end

  always @(posedge clk) begin
    if ((rst_n && start && busy === 1'b0) || (rst_n && out_valid === 1'b1)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Close a sender burst with a random gap; some bursts run long with no gap.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      if (gap > 0) begin
        start    <= 1'b0;
        drive_on = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_word(kind_t k, logic [7:0] data, logic commit);
    in_item_t w;
    w.kind      = k;
    w.data_byte = data;
    w.commit    = commit;
    start    <= 1'b1;
    in_item  <= w;
    drive_on = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pace();
  endtask

  // Hold off the sender until every expected result word has come back.
  task automatic wait_drained();
    if (drive_on) begin
      start    <= 1'b0;
      drive_on = 1'b0;
    end
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    kind_t    k;
    logic     commit;
    int       sel;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle kinds and a done while idle.
    send_word(KIND_STATUS, 8'hA5, 1'b1);
    send_word(KIND_SPARE, 8'h5A, 1'b1);
    send_word(KIND_DONE, 8'hFF, 1'b1);

    // Fill from index 0 while idle: the write that fills the ring kicks a burst.
    repeat (RING_DEPTH - 1) send_word(KIND_WRITE, 8'($urandom), 1'b0);
    // Fill behind the running chain across the tail wrap until writes are refused.
    repeat (RING_DEPTH - 1) send_word(KIND_WRITE, 8'($urandom), 1'b0);
    send_word(KIND_WRITE, 8'hFF, 1'b0);
    send_word(KIND_WRITE, 8'h00, 1'b1);
    send_word(KIND_DONE, 8'h00, 1'b0);
    send_word(KIND_DONE, 8'h00, 1'b0);
    send_word(KIND_DONE, 8'h00, 1'b0);
    send_word(KIND_STATUS, 8'h00, 1'b0);
    send_word(KIND_DONE, 8'h00, 1'b0);

    // Two bytes at the ring end: the second wraps the tail and kicks a burst.
    send_word(KIND_WRITE, 8'h81, 1'b0);
    send_word(KIND_WRITE, 8'h7E, 1'b0);
    send_word(KIND_DONE, 8'h00, 1'b0);

    // Short chain started by a commit.
    send_word(KIND_WRITE, 8'h00, 1'b1);
    send_word(KIND_WRITE, 8'hFF, 1'b0);
    send_word(KIND_DONE, 8'h00, 1'b0);
    send_word(KIND_DONE, 8'h00, 1'b0);
    wait_drained();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (flood_left == 0 && $urandom_range(0, 39) == 0) flood_left = $urandom_range(50, 200);
      sel = $urandom_range(0, 99);
      if (flood_left > 0) begin
        flood_left--;
        k      = (sel < 96) ? KIND_WRITE : KIND_DONE;
        commit = ($urandom_range(0, 15) == 0);
      end else begin
        if (sel < 55)      k = KIND_WRITE;
        else if (sel < 85) k = KIND_DONE;
        else if (sel < 95) k = KIND_STATUS;
        else               k = KIND_SPARE;
        commit = ($urandom_range(0, 2) == 0);
      end
      send_word(k, 8'($urandom), commit);
      if (i % 300 == 299) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/txrdf_pkg.sv
rtl/core/txrdf_in_stage.sv
rtl/core/txrdf_ring_ctrl.sv
rtl/core/tx_ring_dma_burst_feeder.sv
rtl/core/txrdf_checker.sv
tb/sv/tx_ring_dma_burst_feeder_tb.sv
